### rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the generational slot allocator: request
// codes, the request and response payloads and bitmap word helpers.
// ----------------------------------------------------------------------------
package gsa_pkg;

	// handle layout: slot in the upper field, generation in the lower
	localparam int HANDLE_W    = 28;
	localparam int GEN_W       = 16;
	localparam int SLOT_FLD_W  = 12;
	localparam int WORD_BITS   = 64;
	localparam int WORD_MSB    = 63;
	localparam int BIT_IDX_W   = 6;

	typedef enum logic [2:0] {
		REQ_SPAWN    = 3'd0,
		REQ_MARK     = 3'd1,
		REQ_COMMIT   = 3'd2,
		REQ_VALIDATE = 3'd3,
		REQ_SCAN     = 3'd4
	} gsa_req_code_t;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [HANDLE_W-1:0] handle;
	} gsa_req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] result_handle;
		logic                done_ok;
	} gsa_rsp_t;

	// bits of a word whose slot index lies in [1, hw)
	function automatic logic [WORD_MSB:0] valid_mask(input logic [31:0] base,
		input logic [31:0] hw);
		logic [WORD_MSB:0] m;
		logic [31:0]       idx;
		m = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			idx  = base + 32'(i);
			m[i] = (idx != 32'd0) && (idx < hw);
		end
		return m;
	endfunction

	// bits at or above a start offset
	function automatic logic [WORD_MSB:0] geq_mask(input logic [BIT_IDX_W-1:0] off);
		logic [WORD_MSB:0] m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (BIT_IDX_W'(i) >= off);
		end
		return m;
	endfunction

	// index of the lowest set bit
	function automatic logic [BIT_IDX_W-1:0] find_first(input logic [WORD_MSB:0] v);
		logic [BIT_IDX_W-1:0] r;
		r = '0;
		for (int i = WORD_MSB; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### rtl/generational_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator_top
// Handle allocator over a fixed slot pool with generation counters, a LIFO
// free list, two-phase removal and a scan over live slots.
// ----------------------------------------------------------------------------
//  channel   | signals                 | transfer
//  ----------+-------------------------+----------------------------------
//  request   | start, busy, req        | start high while busy low
//  response  | done, rsp               | done high for one cycle, no stall
//
// spawn, mark and validate read the bitmap word and, but for a fresh spawn, the
// slot entry; spawn and mark write the bitmap word back. nil or out-of-range
// requests answer straight from idle. scan reads the bitmap words in order from
// the start slot, then the generation of the first live slot; commit latches and
// rewrites every word below the high-water mark and bumps each doomed slot.
// reset is asynchronous; no clearing pass, bits above the high-water mark
// are masked on every read. the receiver cannot stall responses.
module generational_slot_allocator_top
	import gsa_pkg::*;
#(
	parameter int SLOT_COUNT = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  gsa_req_t req,
	output logic     done,
	output gsa_rsp_t rsp
);

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int HW    = SW + 1;
	localparam int WORDS = (SLOT_COUNT + WORD_MSB) / WORD_BITS;
	localparam int WAW   = (SW > BIT_IDX_W) ? SW - BIT_IDX_W : 1;
	localparam int BMW   = 3 * WORD_BITS;
	localparam int SMW   = GEN_W + SW;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SPAWN  = 8'b0000_0010,
		ST_CHECK  = 8'b0000_0100,
		ST_SC_CHK = 8'b0000_1000,
		ST_SC_GEN = 8'b0001_0000,
		ST_C_WORD = 8'b0010_0000,
		ST_C_FIND = 8'b0100_0000,
		ST_C_BUMP = 8'b1000_0000
	} state_t;

	function automatic logic [WAW-1:0] word_of(input logic [SW-1:0] s);
		return WAW'(s >> BIT_IDX_W);
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [WAW-1:0] w,
		input logic [BIT_IDX_W-1:0] b);
		return SW'((32'(w) << BIT_IDX_W) | 32'(b));
	endfunction

	state_t               state_q, state_d;
	logic [SW-1:0]        head_q, head_d;
	logic [HW-1:0]        hw_q, hw_d;
	logic                 pend_q, pend_d;
	logic [2:0]           req_q, req_d;
	logic [SW-1:0]        slot_q, slot_d;
	logic [GEN_W-1:0]     gen_q, gen_d;
	logic [WAW-1:0]       word_q, word_d;
	logic                 first_q, first_d;
	logic [BIT_IDX_W-1:0] off_q, off_d;
	logic                 fresh_q, fresh_d;
	logic [WORD_MSB:0]    alive_q, alive_d;
	logic [WORD_MSB:0]    doomed_q, doomed_d;
	logic                 done_q, done_d;
	gsa_rsp_t             rsp_q, rsp_d;

	logic                 bm_we, bm_re;
	logic [WAW-1:0]       bm_waddr, bm_raddr;
	logic [BMW-1:0]       bm_wdata, bm_rdata;
	logic                 sm_we, sm_re;
	logic [SW-1:0]        sm_waddr, sm_raddr;
	logic [SMW-1:0]       sm_wdata, sm_rdata;

	logic                 accept;
	logic [SLOT_FLD_W-1:0] hs;
	logic                 hs_ok;
	logic [31:0]          scan_start;
	logic [SW-1:0]        scan_slot;
	logic [WORD_MSB:0]    vmask, bm_alive, bm_nasc, bm_doom, bit_m, cand;
	logic [GEN_W-1:0]     rd_gen;
	logic                 last_word, hit;
	logic [SW-1:0]        pick_slot;

	// bitmap words: doomed, nascent, alive
	gsa_ram #(.DEPTH(WORDS), .AW(WAW), .WIDTH(BMW)) u_bitmap (
		.clk  (clk),
		.we   (bm_we),
		.waddr(bm_waddr),
		.wdata(bm_wdata),
		.re   (bm_re),
		.raddr(bm_raddr),
		.rdata(bm_rdata)
	);

	// per-slot entries: free link, generation
	gsa_ram #(.DEPTH(SLOT_COUNT), .AW(SW), .WIDTH(SMW)) u_slots (
		.clk  (clk),
		.we   (sm_we),
		.waddr(sm_waddr),
		.wdata(sm_wdata),
		.re   (sm_re),
		.raddr(sm_raddr),
		.rdata(sm_rdata)
	);

	// request decode and masked view of the bitmap word just read
	assign accept     = start && (state_q == ST_IDLE);
	assign hs         = req.handle[GEN_W +: SLOT_FLD_W];
	assign hs_ok      = (hs != '0) && (32'(hs) < SLOT_COUNT);
	assign scan_start = (req.handle == '0) ? 32'd1 : 32'(hs) + 32'd1;
	assign scan_slot  = SW'(scan_start);
	assign vmask      = valid_mask(32'(word_q) << BIT_IDX_W, 32'(hw_q));
	assign bm_alive   = bm_rdata[WORD_MSB:0] & vmask;
	assign bm_nasc    = bm_rdata[WORD_BITS +: WORD_BITS] & vmask;
	assign bm_doom    = bm_rdata[2*WORD_BITS +: WORD_BITS] & vmask;
	assign bit_m      = {{WORD_MSB{1'b0}}, 1'b1} << slot_q[BIT_IDX_W-1:0];
	assign rd_gen     = sm_rdata[GEN_W-1:0];
	assign last_word  = ((32'(word_q) << BIT_IDX_W) + 32'(WORD_BITS)) >= 32'(hw_q);
	assign cand       = bm_alive & ~bm_nasc & (first_q ? geq_mask(off_q) : '1);
	assign hit        = (cand != '0);
	assign pick_slot  = slot_of(word_q,
		find_first((state_q == ST_C_FIND) ? doomed_q : cand));

	// sequencer and memory control
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		hw_d     = hw_q;
		pend_d   = pend_q;
		req_d    = req_q;
		slot_d   = slot_q;
		gen_d    = gen_q;
		word_d   = word_q;
		first_d  = first_q;
		off_d    = off_q;
		fresh_d  = fresh_q;
		alive_d  = alive_q;
		doomed_d = doomed_q;
		done_d   = 1'b0;
		rsp_d    = rsp_q;
		bm_we    = 1'b0;
		bm_waddr = word_q;
		bm_wdata = '0;
		bm_re    = 1'b0;
		bm_raddr = word_q;
		sm_we    = 1'b0;
		sm_waddr = slot_q;
		sm_wdata = '0;
		sm_re    = 1'b0;
		sm_raddr = slot_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_d = req.req_type;
					gen_d = req.handle[GEN_W-1:0];
					case (req.req_type)
						REQ_SPAWN: begin
							if (head_q != '0) begin
								slot_d   = head_q;
								word_d   = word_of(head_q);
								fresh_d  = 1'b0;
								bm_re    = 1'b1;
								bm_raddr = word_of(head_q);
								sm_re    = 1'b1;
								sm_raddr = head_q;
								state_d  = ST_SPAWN;
							end else if (32'(hw_q) < SLOT_COUNT) begin
								slot_d   = SW'(hw_q);
								word_d   = word_of(SW'(hw_q));
								fresh_d  = 1'b1;
								hw_d     = hw_q + HW'(1);
								bm_re    = 1'b1;
								bm_raddr = word_of(SW'(hw_q));
								sm_we    = 1'b1;
								sm_waddr = SW'(hw_q);
								state_d  = ST_SPAWN;
							end else begin
								done_d = 1'b1;
								rsp_d  = '0;
							end
						end
						REQ_MARK, REQ_VALIDATE: begin
							if (hs_ok) begin
								slot_d   = SW'(hs);
								word_d   = word_of(SW'(hs));
								bm_re    = 1'b1;
								bm_raddr = word_of(SW'(hs));
								sm_re    = 1'b1;
								sm_raddr = SW'(hs);
								state_d  = ST_CHECK;
							end else begin
								done_d = 1'b1;
								rsp_d  = '0;
							end
						end
						REQ_COMMIT: begin
							word_d   = '0;
							bm_re    = 1'b1;
							bm_raddr = '0;
							state_d  = ST_C_WORD;
						end
						REQ_SCAN: begin
							if (scan_start < 32'(hw_q)) begin
								word_d   = word_of(scan_slot);
								off_d    = scan_slot[BIT_IDX_W-1:0];
								first_d  = 1'b1;
								bm_re    = 1'b1;
								bm_raddr = word_of(scan_slot);
								state_d  = ST_SC_CHK;
							end else begin
								done_d = 1'b1;
								rsp_d  = '0;
							end
						end
						default: begin
							done_d = 1'b1;
							rsp_d  = '0;
						end
					endcase
				end
			end

			// pop or fresh slot: set alive and nascent, clear doomed
			ST_SPAWN: begin
				if (!fresh_q) begin
					head_d = sm_rdata[GEN_W +: SW];
				end
				bm_we    = 1'b1;
				bm_wdata = {bm_doom & ~bit_m, bm_nasc | bit_m, bm_alive | bit_m};
				done_d   = 1'b1;
				rsp_d.result_handle = {SLOT_FLD_W'(slot_q), fresh_q ? GEN_W'(0) : rd_gen};
				rsp_d.done_ok       = 1'b1;
				state_d  = ST_IDLE;
			end

			// live check for mark and validate
			ST_CHECK: begin
				done_d  = 1'b1;
				rsp_d   = '0;
				state_d = ST_IDLE;
				if ((|(bm_alive & bit_m)) && (rd_gen == gen_q)) begin
					if (req_q == REQ_VALIDATE) begin
						rsp_d.result_handle = {SLOT_FLD_W'(slot_q), gen_q};
						rsp_d.done_ok       = 1'b1;
					end else if (!(|(bm_doom & bit_m))) begin
						bm_we         = 1'b1;
						bm_wdata      = {bm_doom | bit_m, bm_nasc, bm_alive};
						pend_d        = 1'b1;
						rsp_d.done_ok = 1'b1;
					end
				end
			end

			// scan one word per cycle, next word read in flight
			ST_SC_CHK: begin
				first_d = 1'b0;
				if (hit) begin
					slot_d   = pick_slot;
					sm_re    = 1'b1;
					sm_raddr = pick_slot;
					state_d  = ST_SC_GEN;
				end else if (last_word) begin
					done_d  = 1'b1;
					rsp_d   = '0;
					state_d = ST_IDLE;
				end else begin
					word_d   = word_q + WAW'(1);
					bm_re    = 1'b1;
					bm_raddr = word_q + WAW'(1);
				end
			end

			ST_SC_GEN: begin
				done_d  = 1'b1;
				rsp_d.result_handle = {SLOT_FLD_W'(slot_q), rd_gen};
				rsp_d.done_ok       = 1'b1;
				state_d = ST_IDLE;
			end

			// commit: latch word, nascent dropped
			ST_C_WORD: begin
				alive_d  = bm_alive;
				doomed_d = pend_q ? bm_doom : '0;
				state_d  = ST_C_FIND;
			end

			ST_C_FIND: begin
				if (doomed_q != '0) begin
					slot_d   = pick_slot;
					sm_re    = 1'b1;
					sm_raddr = pick_slot;
					state_d  = ST_C_BUMP;
				end else begin
					bm_we    = 1'b1;
					bm_wdata = {{WORD_BITS{1'b0}}, {WORD_BITS{1'b0}}, alive_q};
					if (last_word) begin
						pend_d  = 1'b0;
						done_d  = 1'b1;
						rsp_d   = '0;
						state_d = ST_IDLE;
					end else begin
						word_d   = word_q + WAW'(1);
						bm_re    = 1'b1;
						bm_raddr = word_q + WAW'(1);
						state_d  = ST_C_WORD;
					end
				end
			end

			// bump generation and push onto the free list
			ST_C_BUMP: begin
				sm_we    = 1'b1;
				sm_wdata = {head_q, rd_gen + GEN_W'(1)};
				head_d   = slot_q;
				doomed_d = doomed_q & ~bit_m;
				alive_d  = alive_q & ~bit_m;
				state_d  = ST_C_FIND;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			hw_q    <= HW'(1);
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			hw_q    <= hw_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		slot_q   <= slot_d;
		gen_q    <= gen_d;
		word_q   <= word_d;
		first_q  <= first_d;
		off_q    <= off_d;
		fresh_q  <= fresh_d;
		alive_q  <= alive_d;
		doomed_q <= doomed_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gsa_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/gsa_checker.sv
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks of the slot allocator's transaction sequencing.
// ----------------------------------------------------------------------------
module gsa_checker
	import gsa_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input gsa_rsp_t rsp
);

	// an accepted transaction answers at once or keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction neither answered nor busy");

	// a response only follows an accept or a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("response without a transaction in flight");

	// a non-nil handle is only returned with success
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.result_handle != '0)) |-> rsp.done_ok)
		else $error("handle returned without done_ok");

endmodule

bind generational_slot_allocator_top gsa_checker u_gsa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
